### rtl/core/obfp_pkg.sv
// Shared types and constants of the object block frame parser.
package obfp_pkg;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_START_WORD  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_COLOR_WORD  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_RESYNC_WORD = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_LOW_FIRST   = 2'd3;

  localparam logic [15:0] START_WORD_RST  = 16'hAA55;
  localparam logic [15:0] COLOR_WORD_RST  = 16'hAA56;
  localparam logic [15:0] RESYNC_WORD_RST = 16'h55AA;
  localparam logic        LOW_FIRST_RST   = 1'b1;

  localparam logic [15:0] PREV_WORD_INIT = 16'hFFFF;
  localparam int unsigned NORMAL_WORDS   = 5;
  localparam int unsigned OUT_WORDS      = 6;
  localparam int unsigned FIFO_DEPTH     = 2;

  typedef struct packed {
    logic        csum;
    logic        last;
    logic        color;
    logic [15:0] word;
  } word_entry_t;

endpackage

### rtl/core/obfp_front.sv
// Front end: byte pairing, sync hunt and word tagging.
module obfp_front import obfp_pkg::*; #(
  parameter int unsigned BLK_WORDS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              byte_valid_i,
  input  logic [7:0]        byte_i,
  output logic              push_o,
  output word_entry_t       entry_o
);

  localparam int unsigned CW = $clog2(BLK_WORDS + 1);
  localparam int unsigned NORM_LEN =
    (BLK_WORDS < NORMAL_WORDS) ? BLK_WORDS : NORMAL_WORDS;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_DROP = 2'd1;
  localparam logic [1:0] PH_CSUM = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [15:0]   start_q, color_q, resync_q;
  logic          low_first_q;
  logic [1:0]    phase_q, phase_d;
  logic [7:0]    hold_q, hold_d;
  logic          have_half_q, have_half_d;
  logic [15:0]   prev_q, prev_d;
  logic          kind_q, kind_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   word;
  logic [CW-1:0] len_cur, cnt_inc;
  logic          last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= START_WORD_RST;
      color_q     <= COLOR_WORD_RST;
      resync_q    <= RESYNC_WORD_RST;
      low_first_q <= LOW_FIRST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_START_WORD:  start_q     <= cfg_wdata_i;
        CFG_COLOR_WORD:  color_q     <= cfg_wdata_i;
        CFG_RESYNC_WORD: resync_q    <= cfg_wdata_i;
        CFG_LOW_FIRST:   low_first_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign word    = low_first_q ? {byte_i, hold_q} : {hold_q, byte_i};
  assign len_cur = kind_q ? CW'(BLK_WORDS) : CW'(NORM_LEN);
  assign cnt_inc = cnt_q + 1'b1;
  assign last    = (cnt_inc >= len_cur);

  always_comb begin
    phase_d     = phase_q;
    hold_d      = hold_q;
    have_half_d = have_half_q;
    prev_d      = prev_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    push_o      = 1'b0;
    entry_o     = '{csum: 1'b0, last: 1'b0, color: kind_q, word: word};
    if (byte_valid_i) begin
      if (phase_q == PH_DROP) begin
        phase_d = PH_HUNT;
      end else if (!have_half_q) begin
        hold_d      = byte_i;
        have_half_d = 1'b1;
      end else begin
        have_half_d = 1'b0;
        unique case (phase_q)
          PH_HUNT: begin
            if (prev_q == start_q && word == start_q) begin
              kind_d  = 1'b0;
              phase_d = PH_CSUM;
            end else if (prev_q == start_q && word == color_q) begin
              kind_d  = 1'b1;
              phase_d = PH_CSUM;
            end else begin
              if (prev_q != start_q && word == resync_q) begin
                phase_d = PH_DROP;
              end
              prev_d = word;
            end
          end
          PH_CSUM: begin
            push_o       = 1'b1;
            entry_o.csum = 1'b1;
            cnt_d        = '0;
            phase_d      = PH_DATA;
          end
          PH_DATA: begin
            push_o       = 1'b1;
            entry_o.last = last;
            cnt_d        = cnt_inc;
            if (last) begin
              phase_d = PH_HUNT;
              prev_d  = PREV_WORD_INIT;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      hold_q      <= '0;
      have_half_q <= 1'b0;
      prev_q      <= PREV_WORD_INIT;
      kind_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      hold_q      <= hold_d;
      have_half_q <= have_half_d;
      prev_q      <= prev_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
    end
  end

  a_drop_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DROP) |-> !have_half_q)
    else $error("drop phase with half word held");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q < len_cur))
    else $error("word count past block length");

endmodule

### rtl/core/obfp_fifo.sv
// Short word queue between the front and back ends.
module obfp_fifo import obfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  word_entry_t entry_i,
  output logic        full_o,
  output logic        valid_o,
  output word_entry_t entry_o,
  input  logic        pop_i
);

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned NW = $clog2(FIFO_DEPTH + 1);

  word_entry_t   mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;

  assign full_o  = (cnt_q == NW'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

endmodule

### rtl/core/obfp_back.sv
// Back end: checksum accumulation, data capture and result register.
module obfp_back import obfp_pkg::*; #(
  parameter int unsigned BLK_WORDS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  word_entry_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_color_o,
  output logic [95:0] out_data_o
);

  localparam int unsigned CW = $clog2(BLK_WORDS + 1);
  localparam int unsigned IW = (BLK_WORDS > 1) ? $clog2(BLK_WORDS) : 1;

  logic [15:0]   data_q [BLK_WORDS];
  logic [15:0]   sum_q, exp_q, sum_nxt;
  logic [CW-1:0] idx_q;
  logic          out_valid_q;
  logic          out_color_q;
  logic [95:0]   out_data_q;
  logic [15:0]   blk_w [OUT_WORDS];
  logic [95:0]   blk_flat;
  logic          match;

  assign pop_o   = head_valid_i && (!head_i.last || !out_valid_q || out_ready_i);
  assign sum_nxt = sum_q + head_i.word;
  assign match   = pop_o && head_i.last && (sum_nxt == exp_q);

  for (genvar j = 0; j < OUT_WORDS; j++) begin : g_out
    if (j < BLK_WORDS) begin : g_word
      assign blk_w[j] = (idx_q == CW'(j)) ? head_i.word : data_q[j];
    end else begin : g_zero
      assign blk_w[j] = '0;
    end
    assign blk_flat[16*j +: 16] = blk_w[j];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.csum) begin
      for (int k = 0; k < BLK_WORDS; k++) begin
        data_q[k] <= '0;
      end
    end else if (pop_o && idx_q < CW'(BLK_WORDS)) begin
      data_q[idx_q[IW-1:0]] <= head_i.word;
    end
    if (match) begin
      out_color_q <= head_i.color;
      out_data_q  <= blk_flat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      exp_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (head_i.csum) begin
          exp_q <= head_i.word;
          sum_q <= '0;
          idx_q <= '0;
        end else begin
          sum_q <= sum_nxt;
          idx_q <= idx_q + 1'b1;
        end
      end
      if (match) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_color_o = out_color_q;
  assign out_data_o  = out_data_q;

  a_match_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |=> out_valid_q)
    else $error("matching block not presented");

endmodule

### rtl/core/object_block_frame_parser.sv
// Top level of the object block frame parser.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: rx_byte
//  m_axis   out  m_axis_tvalid/m_axis_tready   tuser: is_color_code, tdata: six words
//  cfg      in   cfg_we_i                      cfg_addr_i, cfg_wdata_i
//
//  One byte per cycle while the word queue has room; each result is registered.
//  The front end is paced only by the two-entry word queue; the back end drains
//  one word a cycle and stalls only on a block end while a held result is not taken.
//  Reset returns the parser to hunting with the previous word all ones.
module object_block_frame_parser import obfp_pkg::*; #(
  parameter int unsigned BLK_WORDS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [95:0]       m_axis_tdata,   // signature, pos_x, pos_y, obj_width,
                                            // obj_height, obj_angle (16 bits each)
  output logic              m_axis_tuser    // [0] is_color_code
);

  logic        q_full, q_valid, push, pop, byte_valid;
  word_entry_t push_entry, head_entry;

  assign s_axis_tready = !q_full;
  assign byte_valid    = s_axis_tvalid && s_axis_tready;

  obfp_front #(.BLK_WORDS(BLK_WORDS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (byte_valid),
    .byte_i       (s_axis_tdata),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  obfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (pop)
  );

  obfp_back #(.BLK_WORDS(BLK_WORDS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_color_o  (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

endmodule

### tb/object_block_frame_parser_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the object block frame parser: directed and random byte streams.
module object_block_frame_parser_test;
  import obfp_pkg::*;

  localparam int unsigned WPB          = 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 5000;

  typedef enum logic [1:0] {ST_HUNT, ST_DROP, ST_CSUM, ST_DATA} parse_state_e;

  typedef struct packed {
    logic                 color;
    logic [5:0][15:0]     words;
  } obj_block_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;   // [7:0] rx_byte
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [95:0]       m_axis_tdata;        // signature, pos_x, pos_y, obj_width,
                                          // obj_height, obj_angle (16 bits each)
  logic              m_axis_tuser;        // [0] is_color_code

  object_block_frame_parser #(
    .BLK_WORDS(WPB)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // shadow registers
  logic [15:0] sh_start;
  logic [15:0] sh_color;
  logic [15:0] sh_resync;
  logic        sh_low_first;

  // parser state mirror
  parse_state_e     ps_state;
  logic [7:0]       ps_hold;
  logic             ps_have_half;
  logic [15:0]      ps_prev;
  logic             ps_color;
  logic [15:0]      ps_csum;
  logic [15:0]      ps_sum;
  int unsigned      ps_count;
  logic [5:0][15:0] ps_words;

  obj_block_t  pending_blocks[$];
  obj_block_t  exp_blk;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned blocks_seen = 0;
  int unsigned cfg_settings = 0;
  int unsigned err_cnt = 0;
  int unsigned stall_cycles = 0;
  string       field_name[6] = '{"signature", "pos_x", "pos_y",
                                 "obj_width", "obj_height", "obj_angle"};

  function automatic int unsigned block_words(input logic color);
    if (!color && WPB > NORMAL_WORDS) return NORMAL_WORDS;
    return WPB;
  endfunction

  function automatic void parser_reset();
    sh_start     = START_WORD_RST;
    sh_color     = COLOR_WORD_RST;
    sh_resync    = RESYNC_WORD_RST;
    sh_low_first = LOW_FIRST_RST;
    ps_state     = ST_HUNT;
    ps_hold      = '0;
    ps_have_half = 1'b0;
    ps_prev      = PREV_WORD_INIT;
    ps_color     = 1'b0;
    ps_csum      = '0;
    ps_sum       = '0;
    ps_count     = 0;
    ps_words     = '0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [15:0] w;
    obj_block_t  blk;
    if (ps_state == ST_DROP) begin
      ps_state = ST_HUNT;
      return;
    end
    if (!ps_have_half) begin
      ps_hold = b;
      ps_have_half = 1'b1;
      return;
    end
    ps_have_half = 1'b0;
    w = sh_low_first ? {b, ps_hold} : {ps_hold, b};
    case (ps_state)
      ST_HUNT: begin
        if (ps_prev == sh_start) begin
          if (w == sh_start) begin
            ps_color = 1'b0;
            ps_state = ST_CSUM;
            return;
          end
          if (w == sh_color) begin
            ps_color = 1'b1;
            ps_state = ST_CSUM;
            return;
          end
        end else if (w == sh_resync) begin
          ps_state = ST_DROP;
        end
        ps_prev = w;
      end
      ST_CSUM: begin
        ps_csum  = w;
        ps_sum   = '0;
        ps_count = 0;
        ps_words = '0;
        ps_state = ST_DATA;
      end
      default: begin
        if (ps_count < OUT_WORDS) ps_words[ps_count] = w;
        ps_sum = ps_sum + w;
        ps_count++;
        if (ps_count >= block_words(ps_color)) begin
          ps_state = ST_HUNT;
          ps_prev  = PREV_WORD_INIT;
          if (ps_sum == ps_csum) begin
            blk.color = ps_color;
            blk.words = ps_words;
            pending_blocks = {pending_blocks, blk};
          end
        end
      end
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected block, actual tuser=%0d tdata=%h", $time,
                 m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        exp_blk = pending_blocks.pop_front();
        blocks_seen++;
        if (m_axis_tuser !== exp_blk.color) begin
          $display("%0t: is_color_code mismatch, expected %0d actual %0d", $time,
                   exp_blk.color, m_axis_tuser);
          err_cnt++;
        end
        for (int i = 0; i < 6; i++) begin
          if (m_axis_tdata[16*i +: 16] !== exp_blk.words[i]) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field_name[i],
                     exp_blk.words[i], m_axis_tdata[16*i +: 16]);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    if (sh_low_first) begin
      send_byte(w[7:0]);
      send_byte(w[15:8]);
    end else begin
      send_byte(w[15:8]);
      send_byte(w[7:0]);
    end
  endtask

  function automatic logic [15:0] pick_word(input int unsigned mode);
    case (mode)
      1: return 16'h0000;
      2: return 16'hFFFF;
      default: begin
        case ($urandom_range(7))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return sh_start;
          3: return sh_resync;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_block(input logic color, input logic csum_ok, input int unsigned mode);
    logic [15:0] data[WPB];
    logic [15:0] sum;
    int unsigned n;
    n = block_words(color);
    sum = '0;
    for (int i = 0; i < n; i++) begin
      data[i] = pick_word(mode);
      sum = sum + data[i];
    end
    send_word(sh_start);
    send_word(color ? sh_color : sh_start);
    send_word(csum_ok ? sum : sum ^ 16'(1 << $urandom_range(15)));
    for (int i = 0; i < n; i++) send_word(data[i]);
  endtask

  task automatic align_to_hunt();
    while (!(ps_state == ST_HUNT && !ps_have_half)) send_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = addr;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (addr)
      CFG_START_WORD:  sh_start = val;
      CFG_COLOR_WORD:  sh_color = val;
      CFG_RESYNC_WORD: sh_resync = val;
      CFG_LOW_FIRST:   sh_low_first = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] start_w, input logic [15:0] color_w,
                            input logic [15:0] resync_w, input logic [15:0] low_first);
    wait_drained();
    write_reg(CFG_START_WORD, start_w);
    write_reg(CFG_COLOR_WORD, color_w);
    write_reg(CFG_RESYNC_WORD, resync_w);
    write_reg(CFG_LOW_FIRST, low_first);
    cfg_settings++;
  endtask

  task automatic run_traffic(input int unsigned n_bytes);
    int unsigned first;
    int unsigned r;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      r = $urandom_range(99);
      if (r < 65) begin
        align_to_hunt();
        send_block(1'($urandom_range(1)), $urandom_range(9) != 0, $urandom_range(3));
      end else if (r < 75) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end else if (r < 85) begin
        send_word(sh_resync);
        send_byte(8'($urandom));
      end else if (r < 92) begin
        send_word(sh_start);
        send_word($urandom_range(1) ? sh_color : sh_start);
        repeat ($urandom_range(3)) send_word(pick_word(0));
      end else begin
        send_word(sh_start);
        send_word($urandom_range(1) ? sh_resync : 16'($urandom));
      end
    end
  endtask

  task automatic test_directed_blocks();
    send_block(1'b0, 1'b1, 1);
    send_block(1'b1, 1'b1, 2);
    send_block(1'b0, 1'b0, 0);
    // resync word after a start word is kept as the previous word
    send_word(sh_start);
    send_word(sh_resync);
    send_block(1'b1, 1'b1, 0);
    // resync word drops the following byte
    send_word(sh_resync);
    send_byte(8'h55);
    send_block(1'b0, 1'b1, 0);
    // odd byte shifts pairing so the bytes of the following word are split across two words
    send_byte(8'hA5);
    send_word(16'hAA55);
    send_byte(8'h00);
    align_to_hunt();
    send_block(1'b1, 1'b1, 0);
  endtask

  task automatic test_register_extremes();
    // low bit of a wide value selects high byte first
    set_config(16'hAA55, 16'hAA56, 16'h55AA, 16'hFFFE);
    send_block(1'b0, 1'b1, 0);
    send_block(1'b1, 1'b1, 0);
    // start word equal to the hunt seed value
    set_config(16'hFFFF, 16'h0000, 16'h0001, 16'h0001);
    send_word(16'hFFFF);
    send_word(16'h1234);
    send_block(1'b1, 1'b1, 0);
    run_traffic(40);
    // both sync words equal: start word wins
    set_config(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_block(1'b0, 1'b1, 0);
    send_block(1'b1, 1'b1, 2);
    run_traffic(40);
    set_config(16'h8001, 16'h7FFE, 16'hFFFF, 16'h0001);
    run_traffic(40);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    logic [15:0] start_w;
    start_w = 16'($urandom);
    set_config(start_w, $urandom_range(3) == 0 ? start_w + 16'd1 : 16'($urandom),
               16'($urandom), 16'($urandom));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_traffic(130);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    set_config(START_WORD_RST, COLOR_WORD_RST, RESYNC_WORD_RST, 16'(LOW_FIRST_RST));
    hold_cycles = 400;
    repeat (8) send_block(1'($urandom_range(1)), 1'b1, 0);
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      send_block(1'($urandom_range(1)), 1'b1, 0);
      send_block(1'($urandom_range(1)), 1'b1, 0);
      wait_drained();
    end
  endtask

  initial begin
    parser_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_blocks();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(83, 0);
    test_random_traffic(0, 83);
    test_random_traffic(14, 14);
    test_output_backpressure();
    test_sender_pause();

    wait_drained();
    $display("Covered %0d bytes over %0d register settings, %0d blocks checked.",
             bytes_sent, cfg_settings, blocks_seen);
    $display("Streams mixed good and bad checksums, resync drops, noise and stalls.");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/obfp_pkg.sv
rtl/core/obfp_front.sv
rtl/core/obfp_fifo.sv
rtl/core/obfp_back.sv
rtl/core/object_block_frame_parser.sv
tb/object_block_frame_parser_test.sv
